>>> src/elh_pkg.sv
`timescale 1ns / 1ps

package elh_pkg;

    localparam int unsigned TRACKED_VECTORS_DEF = 10;
    localparam int unsigned HIST_VECTORS        = 16;
    localparam int unsigned ZONES               = 4;

    localparam int unsigned OP_W      = 2;
    localparam int unsigned VEC_W     = 8;
    localparam int unsigned TS_W      = 64;
    localparam int unsigned CNT_W     = 64;
    localparam int unsigned LIMIT_W   = 32;
    localparam int unsigned ZONE_W    = $clog2(ZONES);
    localparam int unsigned CFG_IDX_W = 2;

    localparam int unsigned HIST_IDX_W = $clog2(HIST_VECTORS);
    localparam int unsigned CNT_DEPTH  = HIST_VECTORS * ZONES;
    localparam int unsigned CNT_AW     = $clog2(CNT_DEPTH);

    localparam logic [OP_W-1:0] OP_RAISE = 2'd0;
    localparam logic [OP_W-1:0] OP_ENTRY = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_ZONE0_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ZONE1_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ZONE2_LIMIT = 2'd2;

    localparam logic [LIMIT_W-1:0] LIMIT0_RESET = 32'd10000;
    localparam logic [LIMIT_W-1:0] LIMIT1_RESET = 32'd100000;
    localparam logic [LIMIT_W-1:0] LIMIT2_RESET = 32'd1000000;

    localparam logic [ZONE_W-1:0] ZONE_0 = 2'd0;
    localparam logic [ZONE_W-1:0] ZONE_1 = 2'd1;
    localparam logic [ZONE_W-1:0] ZONE_2 = 2'd2;
    localparam logic [ZONE_W-1:0] ZONE_3 = 2'd3;

    localparam logic RESULT_ZONE  = 1'b0;
    localparam logic RESULT_COUNT = 1'b1;

    typedef struct packed {
        logic capture;
        logic ts_wr;
        logic ts_rd;
        logic lat_load;
        logic cnt_rd_read;
        logic cnt_rd_classify;
        logic cnt_wr;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            tracked;
        logic            out_free;
    } t_dp_status;

endpackage

>>> src/elh_controller.sv
`timescale 1ns / 1ps

module elh_controller (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  elh_pkg::t_dp_status i_status,
    output elh_pkg::t_dp_cmd    o_cmd
);
    import elh_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_LATENCY,
        ST_CLASSIFY,
        ST_UPDATE,
        ST_EMIT
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_ready = (r_state == ST_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_DECODE;
                end
            end
            ST_DECODE: begin
                case (i_status.op)
                    OP_RAISE: begin
                        o_cmd.ts_wr = i_status.tracked;
                        n_state     = ST_IDLE;
                    end
                    OP_ENTRY: begin
                        if (i_status.tracked) begin
                            o_cmd.ts_rd = 1'b1;
                            n_state     = ST_LATENCY;
                        end else begin
                            n_state = ST_IDLE;
                        end
                    end
                    OP_READ: begin
                        o_cmd.cnt_rd_read = 1'b1;
                        n_state           = ST_EMIT;
                    end
                    default: begin
                        n_state = ST_IDLE;
                    end
                endcase
            end
            ST_LATENCY: begin
                o_cmd.lat_load = 1'b1;
                n_state        = ST_CLASSIFY;
            end
            ST_CLASSIFY: begin
                o_cmd.cnt_rd_classify = 1'b1;
                n_state               = ST_UPDATE;
            end
            ST_UPDATE: begin
                o_cmd.cnt_wr = 1'b1;
                n_state      = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

`ifndef ASSERT_OFF
    a_capture_to_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.capture |=> r_state == ST_DECODE)
        else $error("item capture not followed by decode");

    a_one_mem_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.ts_wr, o_cmd.ts_rd, o_cmd.cnt_rd_read,
                  o_cmd.cnt_rd_classify, o_cmd.cnt_wr}))
        else $error("more than one memory access in a cycle");

    a_wr_after_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.cnt_wr |-> $past(o_cmd.cnt_rd_classify))
        else $error("counter write without preceding counter read");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> i_status.out_free)
        else $error("output register overwritten while occupied");
`endif

endmodule

>>> src/elh_datapath.sv
`timescale 1ns / 1ps

module elh_datapath #(
    parameter int unsigned TRACKED_VECTORS = elh_pkg::TRACKED_VECTORS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [elh_pkg::OP_W-1:0]            i_op,
    input  logic [elh_pkg::VEC_W-1:0]           i_vector,
    input  logic [elh_pkg::TS_W-1:0]            i_timestamp,
    input  logic [elh_pkg::ZONE_W-1:0]          i_read_zone,
    input  logic                                i_cfg_wr,
    input  logic [elh_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [elh_pkg::LIMIT_W-1:0]         i_cfg_data,
    input  elh_pkg::t_dp_cmd                    i_cmd,
    output elh_pkg::t_dp_status                 o_status,
    input  logic                                i_ready,
    output logic                                o_valid,
    output logic                                o_result_kind,
    output logic [elh_pkg::ZONE_W-1:0]          o_zone,
    output logic [elh_pkg::CNT_W-1:0]           o_count_value
);
    import elh_pkg::*;

    localparam int unsigned TS_AW = (TRACKED_VECTORS > 1) ? $clog2(TRACKED_VECTORS) : 1;

    logic [OP_W-1:0]    r_op;
    logic [VEC_W-1:0]   r_vector;
    logic [TS_W-1:0]    r_ts;
    logic [ZONE_W-1:0]  r_read_zone;

    logic [LIMIT_W-1:0] r_limit0;
    logic [LIMIT_W-1:0] r_limit1;
    logic [LIMIT_W-1:0] r_limit2;

    logic [TS_W-1:0]            r_ts_mem [TRACKED_VECTORS];
    logic [TRACKED_VECTORS-1:0] r_ts_vld;
    logic [TS_W-1:0]            r_ts_rdata;
    logic                       r_ts_rvld;
    logic [TS_AW-1:0]           w_ts_idx;

    logic [TS_W-1:0]   r_latency;
    logic [TS_W-1:0]   n_latency;
    logic [ZONE_W-1:0] r_zone;
    logic [ZONE_W-1:0] n_zone;

    logic [CNT_W-1:0]     r_cnt_mem [CNT_DEPTH];
    logic [CNT_DEPTH-1:0] r_cnt_vld;
    logic [CNT_W-1:0]     r_cnt_rdata;
    logic                 r_cnt_rvld;
    logic [CNT_AW-1:0]    w_cnt_raddr;
    logic [CNT_AW-1:0]    w_cnt_waddr;
    logic [CNT_W-1:0]     w_cnt_cur;
    logic [CNT_W-1:0]     n_cnt_wdata;

    logic                 r_out_valid;
    logic                 r_out_kind;
    logic [ZONE_W-1:0]    r_out_zone;
    logic [CNT_W-1:0]     r_out_count;

    assign w_ts_idx = r_vector[TS_AW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op        <= i_op;
            r_vector    <= i_vector;
            r_ts        <= i_timestamp;
            r_read_zone <= i_read_zone;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit0 <= LIMIT0_RESET;
            r_limit1 <= LIMIT1_RESET;
            r_limit2 <= LIMIT2_RESET;
        end else if (i_cfg_wr) begin
            case (i_cfg_index)
                CFG_ZONE0_LIMIT: r_limit0 <= i_cfg_data;
                CFG_ZONE1_LIMIT: r_limit1 <= i_cfg_data;
                CFG_ZONE2_LIMIT: r_limit2 <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ts_wr) begin
            r_ts_mem[w_ts_idx] <= r_ts;
        end
        if (i_cmd.ts_rd) begin
            r_ts_rdata <= r_ts_mem[w_ts_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ts_vld  <= '0;
            r_ts_rvld <= 1'b0;
        end else begin
            if (i_cmd.ts_wr) begin
                r_ts_vld[w_ts_idx] <= 1'b1;
            end
            if (i_cmd.ts_rd) begin
                r_ts_rvld <= r_ts_vld[w_ts_idx];
            end
        end
    end

    assign n_latency = r_ts - (r_ts_rvld ? r_ts_rdata : '0);

    always_comb begin
        if (r_latency < {{(TS_W-LIMIT_W){1'b0}}, r_limit0}) begin
            n_zone = ZONE_0;
        end else if (r_latency < {{(TS_W-LIMIT_W){1'b0}}, r_limit1}) begin
            n_zone = ZONE_1;
        end else if (r_latency < {{(TS_W-LIMIT_W){1'b0}}, r_limit2}) begin
            n_zone = ZONE_2;
        end else begin
            n_zone = ZONE_3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.lat_load) begin
            r_latency <= n_latency;
        end
        if (i_cmd.cnt_rd_classify) begin
            r_zone <= n_zone;
        end
    end

    assign w_cnt_raddr = i_cmd.cnt_rd_classify ? {r_vector[HIST_IDX_W-1:0], n_zone}
                                               : {r_vector[HIST_IDX_W-1:0], r_read_zone};
    assign w_cnt_waddr = {r_vector[HIST_IDX_W-1:0], r_zone};
    assign w_cnt_cur   = r_cnt_rvld ? r_cnt_rdata : '0;
    assign n_cnt_wdata = w_cnt_cur + CNT_W'(1);

    always_ff @(posedge i_clk) begin
        if (i_cmd.cnt_wr) begin
            r_cnt_mem[w_cnt_waddr] <= n_cnt_wdata;
        end
        if (i_cmd.cnt_rd_read || i_cmd.cnt_rd_classify) begin
            r_cnt_rdata <= r_cnt_mem[w_cnt_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_vld  <= '0;
            r_cnt_rvld <= 1'b0;
        end else begin
            if (i_cmd.cnt_wr) begin
                r_cnt_vld[w_cnt_waddr] <= 1'b1;
            end
            if (i_cmd.cnt_rd_read || i_cmd.cnt_rd_classify) begin
                r_cnt_rvld <= r_cnt_vld[w_cnt_raddr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            if (r_op == OP_READ) begin
                r_out_kind  <= RESULT_COUNT;
                r_out_zone  <= ZONE_0;
                r_out_count <= w_cnt_cur;
            end else begin
                r_out_kind  <= RESULT_ZONE;
                r_out_zone  <= r_zone;
                r_out_count <= '0;
            end
        end
    end

    assign o_status.op       = r_op;
    assign o_status.tracked  = (r_vector < VEC_W'(TRACKED_VECTORS));
    assign o_status.out_free = !r_out_valid || i_ready;

    assign o_valid       = r_out_valid;
    assign o_result_kind = r_out_kind;
    assign o_zone        = r_out_zone;
    assign o_count_value = r_out_count;

endmodule

>>> src/event_latency_histogram_top.sv
`timescale 1ns / 1ps
// Items are handled one at a time: a new item is accepted only once the sequencer is idle.
// An entry item walks raise-time read, subtract, classify, counter update, output; a read
// item walks counter read, output. The output step waits until the output register is free.
// The output register holds a finished result while the next item is accepted.
// Reset (synchronous, active low) restores the zone limits and clears all raise times
// and counters at once through per-entry valid bits.

module event_latency_histogram_top #(
    parameter int unsigned TRACKED_VECTORS = elh_pkg::TRACKED_VECTORS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [elh_pkg::OP_W-1:0]      i_op,
    input  logic [elh_pkg::VEC_W-1:0]     i_vector,
    input  logic [elh_pkg::TS_W-1:0]      i_timestamp,
    input  logic [elh_pkg::ZONE_W-1:0]    i_read_zone,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_result_kind,
    output logic [elh_pkg::ZONE_W-1:0]    o_zone,
    output logic [elh_pkg::CNT_W-1:0]     o_count_value,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [elh_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [elh_pkg::LIMIT_W-1:0]   i_cfg_data
);
    import elh_pkg::*;

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    assign o_cfg_ready = 1'b1;

    elh_controller u_controller (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    elh_datapath #(
        .TRACKED_VECTORS (TRACKED_VECTORS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_op          (i_op),
        .i_vector      (i_vector),
        .i_timestamp   (i_timestamp),
        .i_read_zone   (i_read_zone),
        .i_cfg_wr      (i_cfg_valid && o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .i_ready       (i_ready),
        .o_valid       (o_valid),
        .o_result_kind (o_result_kind),
        .o_zone        (o_zone),
        .o_count_value (o_count_value)
    );

endmodule

>>> tb/tb_event_latency_histogram_top.sv
`timescale 1ns / 1ps

typedef struct {
    logic                      kind;
    logic [elh_pkg::ZONE_W-1:0] zone;
    logic [elh_pkg::CNT_W-1:0]  value;
} t_hist_result;

class histogram_scoreboard;
    logic [elh_pkg::LIMIT_W-1:0] limit [3];
    logic [elh_pkg::TS_W-1:0]    raise_time [elh_pkg::TRACKED_VECTORS_DEF];
    logic [elh_pkg::CNT_W-1:0]   zone_count [elh_pkg::CNT_DEPTH];
    t_hist_result                expected_results [$];
    int                          mismatches;
    int                          zone_checks;
    int                          read_checks;
    int                          handled;

    function new();
        limit[0] = elh_pkg::LIMIT0_RESET;
        limit[1] = elh_pkg::LIMIT1_RESET;
        limit[2] = elh_pkg::LIMIT2_RESET;
        foreach (raise_time[i]) raise_time[i] = '0;
        foreach (zone_count[i]) zone_count[i] = '0;
        mismatches  = 0;
        zone_checks = 0;
        read_checks = 0;
        handled     = 0;
    endfunction

    function void write_limit(logic [elh_pkg::CFG_IDX_W-1:0] idx,
                              logic [elh_pkg::LIMIT_W-1:0] data);
        case (idx)
            elh_pkg::CFG_ZONE0_LIMIT: limit[0] = data;
            elh_pkg::CFG_ZONE1_LIMIT: limit[1] = data;
            elh_pkg::CFG_ZONE2_LIMIT: limit[2] = data;
            default: ;
        endcase
    endfunction

    function logic [elh_pkg::ZONE_W-1:0] zone_for_latency(logic [elh_pkg::TS_W-1:0] lat);
        if (lat < {32'b0, limit[0]}) return elh_pkg::ZONE_0;
        if (lat < {32'b0, limit[1]}) return elh_pkg::ZONE_1;
        if (lat < {32'b0, limit[2]}) return elh_pkg::ZONE_2;
        return elh_pkg::ZONE_3;
    endfunction

    function void record_event(logic [elh_pkg::OP_W-1:0] op, logic [elh_pkg::VEC_W-1:0] vec,
                               logic [elh_pkg::TS_W-1:0] ts,
                               logic [elh_pkg::ZONE_W-1:0] rz);
        t_hist_result                 r;
        logic [elh_pkg::ZONE_W-1:0]   z;
        logic [elh_pkg::CNT_AW-1:0]   idx;
        case (op)
            elh_pkg::OP_RAISE: begin
                if (vec < elh_pkg::TRACKED_VECTORS_DEF) begin
                    raise_time[vec] = ts;
                    handled++;
                end
            end
            elh_pkg::OP_ENTRY: begin
                if (vec < elh_pkg::TRACKED_VECTORS_DEF) begin
                    z = zone_for_latency(ts - raise_time[vec]);
                    idx = {vec[elh_pkg::HIST_IDX_W-1:0], z};
                    zone_count[idx] = zone_count[idx] + 1'b1;
                    r.kind  = elh_pkg::RESULT_ZONE;
                    r.zone  = z;
                    r.value = '0;
                    expected_results.push_back(r);
                    handled++;
                end
            end
            elh_pkg::OP_READ: begin
                idx = {vec[elh_pkg::HIST_IDX_W-1:0], rz};
                r.kind  = elh_pkg::RESULT_COUNT;
                r.zone  = elh_pkg::ZONE_0;
                r.value = zone_count[idx];
                expected_results.push_back(r);
                handled++;
            end
            default: ;
        endcase
    endfunction

    function void compare_result(logic kind, logic [elh_pkg::ZONE_W-1:0] zone,
                                 logic [elh_pkg::CNT_W-1:0] value);
        t_hist_result e;
        if (expected_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("ERROR %0t: unexpected result kind=%0d zone=%0d count=%0h",
                         $time, kind, zone, value);
            return;
        end
        e = expected_results.pop_front();
        if (e.kind == elh_pkg::RESULT_ZONE) zone_checks++;
        else read_checks++;
        if (kind !== e.kind || zone !== e.zone || value !== e.value) begin
            mismatches++;
            if (mismatches <= 10)
                $display({"ERROR %0t: expected kind=%0d zone=%0d count=%0h, ",
                          "got kind=%0d zone=%0d count=%0h"},
                         $time, e.kind, e.zone, e.value, kind, zone, value);
        end
    endfunction

    function int pending();
        return expected_results.size();
    endfunction
endclass

module tb_event_latency_histogram_top;
    import elh_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int IDLE_PCT     = 29;
    localparam int HOLD_CYCLES  = 300;
    localparam int STALL_LIMIT  = 2000;
    localparam int PHASE_ITEMS  = 100;
    localparam int NUM_PHASES   = 8;
    localparam int DRAIN_CYCLES = 8;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_ready;
    logic [OP_W-1:0]      i_op;
    logic [VEC_W-1:0]     i_vector;
    logic [TS_W-1:0]      i_timestamp;
    logic [ZONE_W-1:0]    i_read_zone;
    logic                 o_valid;
    logic                 i_ready;
    logic                 o_result_kind;
    logic [ZONE_W-1:0]    o_zone;
    logic [CNT_W-1:0]     o_count_value;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [LIMIT_W-1:0]   i_cfg_data;

    histogram_scoreboard sb = new();
    bit                  idle_en;
    bit                  hold_request;
    int                  hold_left;
    int                  items_sent;
    int                  stall_cycles;
    logic [LIMIT_W-1:0]  phase_limits [NUM_PHASES][3];

    event_latency_histogram_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_op          (i_op),
        .i_vector      (i_vector),
        .i_timestamp   (i_timestamp),
        .i_read_zone   (i_read_zone),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_result_kind (o_result_kind),
        .o_zone        (o_zone),
        .o_count_value (o_count_value),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // hold off the result side for a long stretch on request
    always @(negedge i_clk) begin
        if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= !(idle_en && $urandom_range(0, 99) < IDLE_PCT);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            sb.compare_result(o_result_kind, o_zone, o_count_value);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("Timeout after %0d cycles without progress", stall_cycles);
                $display("event_latency_histogram_top verification failed");
                $finish;
            end
        end
    end

    task automatic send_item(input logic [OP_W-1:0] op, input logic [VEC_W-1:0] vec,
                             input logic [TS_W-1:0] ts, input logic [ZONE_W-1:0] rz);
        while (idle_en && $urandom_range(0, 99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_op        <= op;
        i_vector    <= vec;
        i_timestamp <= ts;
        i_read_zone <= rz;
        do @(posedge i_clk); while (!o_ready);
        sb.record_event(op, vec, ts, rz);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic configure(input logic [LIMIT_W-1:0] l0, input logic [LIMIT_W-1:0] l1,
                             input logic [LIMIT_W-1:0] l2);
        logic [LIMIT_W-1:0]   vals [3];
        logic [CFG_IDX_W-1:0] idx [3];
        vals = '{l0, l1, l2};
        idx  = '{CFG_ZONE0_LIMIT, CFG_ZONE1_LIMIT, CFG_ZONE2_LIMIT};
        for (int k = 0; k < 3; k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx[k];
            i_cfg_data  <= vals[k];
            do @(posedge i_clk); while (!o_cfg_ready);
            sb.write_limit(idx[k], vals[k]);
            @(negedge i_clk);
        end
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    function automatic logic [TS_W-1:0] pick_latency();
        logic [TS_W-1:0] lim;
        lim = {32'b0, sb.limit[$urandom_range(0, 2)]};
        case ($urandom_range(0, 8))
            0: return '0;
            1: return lim - 1'b1;
            2: return lim;
            3: return lim + 1'b1;
            4: return {32'b0, $urandom_range(0, 2000000)};
            5: return {$urandom, $urandom};
            6: return {32'b0, $urandom};
            7: return '1;
            default: return lim >> 1;
        endcase
    endfunction

    task automatic random_phase(input int n_items);
        int               start;
        int               r;
        logic [VEC_W-1:0] v;
        logic [TS_W-1:0]  t;
        start = sb.handled;
        while (sb.handled - start < n_items) begin
            r = $urandom_range(0, 99);
            v = VEC_W'($urandom_range(0, TRACKED_VECTORS_DEF - 1));
            t = {$urandom, $urandom};
            if (r < 45) begin
                send_item(OP_RAISE, v, t, ZONE_W'($urandom_range(0, 3)));
                send_item(OP_ENTRY, v, t + pick_latency(), ZONE_W'($urandom_range(0, 3)));
            end else if (r < 58) begin
                send_item(OP_ENTRY, v, t, ZONE_W'($urandom_range(0, 3)));
            end else if (r < 80) begin
                send_item(OP_READ, VEC_W'($urandom_range(0, 255)), t,
                          ZONE_W'($urandom_range(0, 3)));
            end else if (r < 88) begin
                send_item(OP_RAISE, v, t, ZONE_W'($urandom_range(0, 3)));
            end else begin
                send_item(OP_W'($urandom_range(0, 3)), VEC_W'($urandom_range(0, 255)), t,
                          ZONE_W'($urandom_range(0, 3)));
            end
        end
    endtask

    initial begin
        logic [TS_W-1:0] boundary_lat [6];
        boundary_lat = '{64'd9999, 64'd10000, 64'd99999, 64'd100000, 64'd999999, 64'd1000000};
        phase_limits[0] = '{LIMIT0_RESET, LIMIT1_RESET, LIMIT2_RESET};
        phase_limits[1] = '{32'd0, 32'd0, 32'd0};
        phase_limits[2] = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
        phase_limits[3] = '{32'd1000, 32'd500, 32'd2000};
        phase_limits[4] = '{32'd5000, 32'd5000, 32'd7000};
        phase_limits[5] = '{$urandom, $urandom, $urandom};
        phase_limits[6] = '{32'd1, 32'd2, 32'hFFFF_FFFF};
        phase_limits[7] = '{32'd300000, 32'd200000, 32'd100000};

        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_op         = OP_RAISE;
        i_vector     = '0;
        i_timestamp  = '0;
        i_read_zone  = ZONE_0;
        i_ready      = 1'b0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = CFG_ZONE0_LIMIT;
        i_cfg_data   = '0;
        idle_en      = 1'b1;
        hold_request = 1'b0;
        hold_left    = 0;
        items_sent   = 0;
        stall_cycles = 0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_item(OP_ENTRY, 8'd0, 64'd5, ZONE_0);
        send_item(OP_ENTRY, 8'd9, '1, ZONE_3);
        send_item(OP_READ, 8'd0, '0, ZONE_0);
        send_item(OP_READ, 8'd9, '0, ZONE_3);
        send_item(OP_READ, 8'hF9, '1, ZONE_3);
        send_item(OP_RAISE, 8'd10, '0, ZONE_0);
        send_item(OP_ENTRY, 8'd10, 64'd50, ZONE_0);
        send_item(OP_RAISE, 8'hFF, '1, ZONE_3);
        send_item(OP_ENTRY, 8'hFF, '0, ZONE_3);
        send_item(OP_UNUSED, 8'd0, '0, ZONE_0);
        send_item(OP_RAISE, 8'd3, 64'hFFFF_FFFF_FFFF_FFF0, ZONE_0);
        send_item(OP_ENTRY, 8'd3, 64'h10, ZONE_0);
        send_item(OP_RAISE, 8'd1, 64'd1000, ZONE_0);
        for (int k = 0; k < 6; k++)
            send_item(OP_ENTRY, 8'd1, 64'd1000 + boundary_lat[k], ZONE_0);
        for (int k = 0; k < ZONES; k++)
            send_item(OP_READ, 8'd1, '0, k[ZONE_W-1:0]);
        send_item(OP_READ, 8'd17, '0, ZONE_2);
        wait_drained();

        for (int p = 0; p < NUM_PHASES; p++) begin
            idle_en = (p != 2);
            configure(phase_limits[p][0], phase_limits[p][1], phase_limits[p][2]);
            if (p == 4) hold_request = 1'b1;
            random_phase(PHASE_ITEMS);
            wait_drained();
        end

        repeat (10) @(posedge i_clk);
        $display("Sent %0d items under %0d threshold settings, including a long output stall",
                 items_sent, NUM_PHASES + 1);
        $display("Checked %0d zone results and %0d counter reads, %0d mismatches",
                 sb.zone_checks, sb.read_checks, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("event_latency_histogram_top verification clean");
        end else begin
            $display("event_latency_histogram_top verification failed");
        end
        $finish;
    end
endmodule
